[hw/rtl/sm4_pkg.sv]
// sm4 cipher package: s-box table, linear transforms and round constants
package sm4_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned WordW     = 32;
  localparam int unsigned HalfW     = 64;
  localparam int unsigned BlockW    = 128;
  localparam int unsigned RoundIdxW = $clog2(NumRounds);

  // register indexes of the configuration port
  localparam logic RegKeyHigh = 1'b0;
  localparam logic RegKeyLow  = 1'b1;

  localparam logic [BlockW-1:0] FkConst = 128'ha3b1bac6_56aa3350_677d9197_b27022dc;

  localparam logic [7:0] SBOX [256] = '{
    8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
    8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
    8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
    8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
    8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
    8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
    8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
    8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
    8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
    8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
    8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
    8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
    8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
    8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
    8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
    8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
  };

  function automatic logic [WordW-1:0] sbox_word(logic [WordW-1:0] v);
    return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
  endfunction

  function automatic logic [WordW-1:0] rotl(logic [WordW-1:0] v, int unsigned n);
    return (v << n) | (v >> (WordW - n));
  endfunction

  // data path transform T
  function automatic logic [WordW-1:0] t_round(logic [WordW-1:0] v);
    logic [WordW-1:0] b;
    b = sbox_word(v);
    return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
  endfunction

  // key schedule transform T'
  function automatic logic [WordW-1:0] t_key(logic [WordW-1:0] v);
    logic [WordW-1:0] b;
    b = sbox_word(v);
    return b ^ rotl(b, 13) ^ rotl(b, 23);
  endfunction

  // ck byte j of word i is (4i+j)*7 mod 256
  function automatic logic [WordW-1:0] ck_word(logic [RoundIdxW-1:0] i);
    logic [WordW-1:0] w;
    logic [9:0]       prod;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      prod = {3'b000, i, 2'(j)} * 10'd7;
      w    = {w[23:0], prod[7:0]};
    end
    return w;
  endfunction

  // one cipher round: state words x0..x3, x0 in the top bits
  function automatic logic [BlockW-1:0] sm4_round(logic [BlockW-1:0] x,
                                                  logic [WordW-1:0] rk);
    logic [WordW-1:0] t;
    t = x[95:64] ^ x[63:32] ^ x[31:0] ^ rk;
    return {x[95:0], x[127:96] ^ t_round(t)};
  endfunction

endpackage

[hw/rtl/sm4_block_cipher.sv]
// sm4 block cipher: round key sequencer and 32-stage unrolled round pipeline
// an accepted request passes through the round stages in order, one round per stage
// throughput: one block per cycle; a stalled output freezes the whole pipeline
// key expansion: after reset and after each key write, a load step and then one
//   round key per cycle, during which no request is accepted
// reset: pipeline emptied, key registers cleared to zero, expansion of the zero key starts
module sm4_block_cipher (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic                            cfg_idx_i,
  input  logic [sm4_pkg::HalfW-1:0]       cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            kind_i,
  input  logic [sm4_pkg::HalfW-1:0]       block_high_i,
  input  logic [sm4_pkg::HalfW-1:0]       block_low_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [sm4_pkg::HalfW-1:0]       result_high_o,
  output logic [sm4_pkg::HalfW-1:0]       result_low_o
);
  import sm4_pkg::*;

  typedef enum logic [1:0] {
    KS_LOAD,
    KS_RUN,
    KS_IDLE
  } ks_state_e;

  ks_state_e              ks_state_q;
  logic [HalfW-1:0]       key_high_q, key_low_q;
  logic [BlockW-1:0]      kw_q;
  logic [RoundIdxW-1:0]   ks_cnt_q;
  logic [WordW-1:0]       rk_q [NumRounds];
  logic [WordW-1:0]       rk_new;

  logic [BlockW-1:0]      st_q     [NumRounds];
  logic                   kind_q   [NumRounds];
  logic                   valid_q  [NumRounds];
  logic [BlockW-1:0]      st_d     [NumRounds];
  logic                   kind_d   [NumRounds];
  logic                   valid_d  [NumRounds];
  logic                   advance;

  // key registers and round key sequencer
  assign rk_new = kw_q[127:96] ^
                  t_key(kw_q[95:64] ^ kw_q[63:32] ^ kw_q[31:0] ^ ck_word(ks_cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_high_q <= '0;
      key_low_q  <= '0;
      ks_state_q <= KS_LOAD;
      ks_cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegKeyHigh: key_high_q <= cfg_data_i;
          RegKeyLow:  key_low_q  <= cfg_data_i;
          default:    key_low_q  <= cfg_data_i;
        endcase
        ks_state_q <= KS_LOAD;
      end else begin
        case (ks_state_q)
          KS_LOAD: begin
            ks_cnt_q   <= '0;
            ks_state_q <= KS_RUN;
          end
          KS_RUN: begin
            ks_cnt_q <= ks_cnt_q + 1'b1;
            if (ks_cnt_q == RoundIdxW'(NumRounds - 1)) ks_state_q <= KS_IDLE;
          end
          KS_IDLE: ks_state_q <= KS_IDLE;
          default: ks_state_q <= KS_LOAD;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ks_state_q == KS_LOAD) begin
      kw_q <= {key_high_q, key_low_q} ^ FkConst;
    end else if (ks_state_q == KS_RUN) begin
      kw_q           <= {kw_q[95:0], rk_new};
      rk_q[ks_cnt_q] <= rk_new;
    end
  end

  // pipeline moves as a whole unless the output holds an unaccepted result
  assign advance    = !valid_q[NumRounds-1] || out_ready_i;
  assign in_ready_o = advance && (ks_state_q == KS_IDLE);

  for (genvar i = 0; i < NumRounds; i++) begin : g_round
    logic [BlockW-1:0] st_in;
    logic              kind_in;
    logic              valid_in;
    logic [WordW-1:0]  rk_sel;

    if (i == 0) begin : g_first
      assign st_in    = {block_high_i, block_low_i};
      assign kind_in  = kind_i;
      assign valid_in = in_valid_i && in_ready_o;
    end else begin : g_next
      assign st_in    = st_q[i-1];
      assign kind_in  = kind_q[i-1];
      assign valid_in = valid_q[i-1];
    end

    // decryption takes the round keys in reverse order
    assign rk_sel     = kind_in ? rk_q[NumRounds-1-i] : rk_q[i];
    assign st_d[i]    = sm4_round(st_in, rk_sel);
    assign kind_d[i]  = kind_in;
    assign valid_d[i] = valid_in;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (advance) begin
        valid_q[i] <= valid_d[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        st_q[i]   <= st_d[i];
        kind_q[i] <= kind_d[i];
      end
    end
  end

  // final word order is reversed
  assign out_valid_o   = valid_q[NumRounds-1];
  assign result_high_o = {st_q[NumRounds-1][31:0],  st_q[NumRounds-1][63:32]};
  assign result_low_o  = {st_q[NumRounds-1][95:64], st_q[NumRounds-1][127:96]};

endmodule
